@@ rtl/tarf_pkg.sv @@
`timescale 1ns / 1ps

package tarf_pkg;

  // header geometry
  localparam int unsigned BLOCK_BYTES  = 512;
  localparam int unsigned OFS_W        = 9;
  localparam int unsigned SIZE_W       = 36;
  localparam int unsigned SKIP_W       = SIZE_W + 1;
  localparam int unsigned OFFSET_W     = 32;
  localparam int unsigned TDATA_W      = 80;
  localparam int unsigned DEF_POSITION_BITS = 32;

  // field offsets inside a header block
  localparam logic [OFS_W-1:0] NAME_END   = OFS_W'(100);
  localparam logic [OFS_W-1:0] SIZE_FIRST = OFS_W'(124);
  localparam logic [OFS_W-1:0] SIZE_END   = OFS_W'(136);
  localparam logic [OFS_W-1:0] TYPE_OFS   = OFS_W'(156);
  localparam logic [OFS_W-1:0] LAST_OFS   = OFS_W'(BLOCK_BYTES - 1);

  // characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_DIR   = 8'h35;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  // result status codes
  localparam logic [1:0] ST_ENTRY = 2'd0;
  localparam logic [1:0] ST_EOA   = 2'd1;
  localparam logic [1:0] ST_ENDED = 2'd2;

  // output queue
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [1:0]          status;
    logic [SIZE_W-1:0]   entry_size;
    logic [OFFSET_W-1:0] data_offset;
    logic [7:0]          type_code;
    logic                is_directory;
    logic                last_result;
  } result_t;

  // results of one accepted byte, in order
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

endpackage

@@ rtl/tarf_parse.sv @@
`timescale 1ns / 1ps

module tarf_parse #(
  parameter int unsigned POSITION_BITS = tarf_pkg::DEF_POSITION_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      byte_i,
  input  logic            last_i,
  output tarf_pkg::push_t push_o
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  logic [1:0]                      phase_q, phase_d;
  logic [tarf_pkg::OFS_W-1:0]      blk_q, blk_d;
  logic [tarf_pkg::SIZE_W-1:0]     size_q, size_d;
  logic                            stop_q, stop_d;
  logic [7:0]                      type_q, type_d;
  logic                            nempty_q, nempty_d;
  logic                            ndone_q, ndone_d;
  logic                            slash_q, slash_d;
  logic [tarf_pkg::SKIP_W-1:0]     skip_q, skip_d;
  logic [POSITION_BITS-1:0]        pos_q, pos_d;
  logic [POSITION_BITS-1:0]        pos_inc;
  logic [tarf_pkg::SKIP_W-1:0]     skip_round;
  logic                            hdr_v;
  logic                            end_v;
  tarf_pkg::result_t               hdr_res;
  tarf_pkg::result_t               end_res;

  // per-byte header parse and skip count
  always_comb begin
    phase_d    = phase_q;
    blk_d      = blk_q;
    size_d     = size_q;
    stop_d     = stop_q;
    type_d     = type_q;
    nempty_d   = nempty_q;
    ndone_d    = ndone_q;
    slash_d    = slash_q;
    skip_d     = skip_q;
    pos_inc    = pos_q + POSITION_BITS'(1);
    pos_d      = pos_inc;
    hdr_v      = 1'b0;
    hdr_res    = '0;
    skip_round = '0;

    unique case (phase_q)
      PH_HEADER: begin
        if (blk_q == '0) begin
          nempty_d = (byte_i == 8'h00);
          size_d   = '0;
          stop_d   = 1'b0;
          type_d   = '0;
          ndone_d  = 1'b0;
          slash_d  = 1'b0;
        end
        if (blk_q < tarf_pkg::NAME_END && !ndone_d) begin
          if (byte_i == 8'h00) begin
            ndone_d = 1'b1;
          end else begin
            slash_d = (byte_i == tarf_pkg::CH_SLASH);
          end
        end
        if (blk_q >= tarf_pkg::SIZE_FIRST && blk_q < tarf_pkg::SIZE_END && !stop_d) begin
          if (byte_i == 8'h00) begin
            stop_d = 1'b1;
          end else if (byte_i >= tarf_pkg::CH_ZERO && byte_i <= tarf_pkg::CH_SEVEN) begin
            size_d = {size_d[tarf_pkg::SIZE_W-4:0], byte_i[2:0]};
          end
        end
        if (blk_q == tarf_pkg::TYPE_OFS) begin
          type_d = byte_i;
        end
        if (blk_q == tarf_pkg::LAST_OFS) begin
          blk_d = '0;
          hdr_v = 1'b1;
          if (nempty_d) begin
            hdr_res.status = tarf_pkg::ST_EOA;
            phase_d        = PH_DONE;
          end else begin
            hdr_res.status       = tarf_pkg::ST_ENTRY;
            hdr_res.entry_size   = size_d;
            hdr_res.data_offset  = tarf_pkg::OFFSET_W'(pos_inc);
            hdr_res.type_code    = type_d;
            hdr_res.is_directory = (type_d == tarf_pkg::CH_DIR) || slash_d;
            // data length rounded up to whole blocks
            skip_round = {1'b0, size_d} + tarf_pkg::SKIP_W'(tarf_pkg::BLOCK_BYTES - 1);
            skip_round[tarf_pkg::OFS_W-1:0] = '0;
            skip_d  = skip_round;
            phase_d = (skip_round != '0) ? PH_SKIP : PH_HEADER;
          end
        end else begin
          blk_d = blk_q + tarf_pkg::OFS_W'(1);
        end
      end
      PH_SKIP: begin
        if (skip_q != '0) begin
          skip_d = skip_q - tarf_pkg::SKIP_W'(1);
        end
        if (skip_d == '0) begin
          phase_d = PH_HEADER;
          blk_d   = '0;
        end
      end
      default: begin
        // archive ended: only the position advances
      end
    endcase

    // image end report, then back to the reset state
    end_v          = last_i && (phase_d == PH_HEADER || phase_d == PH_SKIP);
    end_res        = '0;
    end_res.status = tarf_pkg::ST_ENDED;
    if (last_i) begin
      phase_d  = PH_HEADER;
      blk_d    = '0;
      size_d   = '0;
      stop_d   = 1'b0;
      type_d   = '0;
      nempty_d = 1'b0;
      ndone_d  = 1'b0;
      slash_d  = 1'b0;
      skip_d   = '0;
      pos_d    = '0;
    end
  end

  // order the results of this byte
  always_comb begin
    push_o = '0;
    if (accept_i) begin
      if (hdr_v) begin
        push_o.push0 = 1'b1;
        push_o.res0  = hdr_res;
        push_o.push1 = end_v;
        push_o.res1  = end_res;
        push_o.res0.last_result = !end_v;
        push_o.res1.last_result = 1'b1;
      end else if (end_v) begin
        push_o.push0 = 1'b1;
        push_o.res0  = end_res;
        push_o.res0.last_result = 1'b1;
      end
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      blk_q    <= '0;
      size_q   <= '0;
      stop_q   <= 1'b0;
      type_q   <= '0;
      nempty_q <= 1'b0;
      ndone_q  <= 1'b0;
      slash_q  <= 1'b0;
      skip_q   <= '0;
      pos_q    <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      blk_q    <= blk_d;
      size_q   <= size_d;
      stop_q   <= stop_d;
      type_q   <= type_d;
      nempty_q <= nempty_d;
      ndone_q  <= ndone_d;
      slash_q  <= slash_d;
      skip_q   <= skip_d;
      pos_q    <= pos_d;
    end
  end

endmodule

@@ rtl/tarf_outq.sv @@
`timescale 1ns / 1ps

module tarf_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tarf_pkg::push_t   push_i,
  output logic              space_o,
  output logic              valid_o,
  input  logic              ready_i,
  output tarf_pkg::result_t head_o
);

  tarf_pkg::result_t                  entry_q [tarf_pkg::OQ_DEPTH];
  logic [tarf_pkg::OQ_PTR_W-1:0]      wr_q, wr_d;
  logic [tarf_pkg::OQ_PTR_W-1:0]      rd_q, rd_d;
  logic [tarf_pkg::OQ_CNT_W-1:0]      cnt_q, cnt_d;
  logic [tarf_pkg::OQ_PTR_W-1:0]      wr_next;
  logic [tarf_pkg::OQ_CNT_W-1:0]      n_push;
  logic                               pop;

  assign valid_o = (cnt_q != '0);
  assign head_o  = entry_q[rd_q];
  // room for the most results one byte can cause
  assign space_o = (cnt_q <= tarf_pkg::OQ_CNT_W'(tarf_pkg::OQ_DEPTH - 2));
  assign pop     = valid_o && ready_i;
  assign wr_next = wr_q + tarf_pkg::OQ_PTR_W'(1);

  // pointer and fill count update
  always_comb begin
    n_push = tarf_pkg::OQ_CNT_W'(push_i.push0) + tarf_pkg::OQ_CNT_W'(push_i.push1);
    wr_d   = wr_q + tarf_pkg::OQ_PTR_W'(n_push);
    rd_d   = pop ? rd_q + tarf_pkg::OQ_PTR_W'(1) : rd_q;
    cnt_d  = cnt_q + n_push - tarf_pkg::OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage, one or two words written per cycle
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < tarf_pkg::OQ_DEPTH; i++) begin
      if (push_i.push0 && wr_q == tarf_pkg::OQ_PTR_W'(i)) begin
        entry_q[i] <= push_i.res0;
      end else if (push_i.push1 && wr_next == tarf_pkg::OQ_PTR_W'(i)) begin
        entry_q[i] <= push_i.res1;
      end
    end
  end

endmodule

@@ rtl/tar_archive_entry_framer.sv @@
`timescale 1ns / 1ps

// ustar entry framer: takes one archive byte per cycle and reports each
// header it completes (entry size, data offset, type byte, directory flag),
// the end-of-archive header, and an image that ends without one. A byte is
// taken every cycle while the four-word result queue has room for two
// words; the header parse, skip counter and position counter settle within
// that same cycle, and the byte's result words are queued. Results leave at
// one word per cycle while the sink is ready. A header's results follow its
// last byte; a byte marked last returns the framer to its reset state.

module tar_archive_entry_framer #(
  parameter int unsigned POSITION_BITS = tarf_pkg::DEF_POSITION_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // archive_byte
  input  logic [7:0]                   s_axis_tdata_i,
  // image_last
  input  logic                         s_axis_tlast_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // status, entry_size, data_offset, type_code, is_directory, zero fill
  output logic [tarf_pkg::TDATA_W-1:0] m_axis_tdata_o,
  // last_result
  output logic                         m_axis_tlast_o
);

  logic              accept;
  logic              space;
  tarf_pkg::push_t   push;
  tarf_pkg::result_t head;

  assign s_axis_tready_o = space;
  assign accept          = s_axis_tvalid_i && space;

  // header parse and skip control
  tarf_parse #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata_i),
    .last_i   (s_axis_tlast_i),
    .push_o   (push)
  );

  // result queue
  tarf_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .head_o  (head)
  );

  // pack the result word
  assign m_axis_tdata_o = {1'b0, head.is_directory, head.type_code, head.data_offset,
                           head.entry_size, head.status};
  assign m_axis_tlast_o = head.last_result;

endmodule

@@ bench/tar_archive_entry_framer_tb.sv @@
`timescale 1ns / 1ps

module tar_archive_entry_framer_tb;
  import tarf_pkg::*;

  localparam int unsigned LONE_BYTES     = 30;
  localparam int unsigned CUT_DATA_BYTES = 30;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned DRAIN_CYCLES   = 20;

  typedef enum logic [1:0] {PH_HEADER, PH_SKIP, PH_DONE} parse_phase_e;

  // ways of writing the octal size field of a generated header
  typedef enum int unsigned {
    SZ_PADDED, SZ_SPACED, SZ_FULL, SZ_EARLY_NUL, SZ_GARBAGE
  } size_style_e;

  logic               clk_i    = 1'b0;
  logic               rst_ni   = 1'b0;
  logic               s_tvalid = 1'b0;
  logic [7:0]         s_tdata  = '0;
  logic               s_tlast  = 1'b0;
  logic               s_tready;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tlast;

  always #1 clk_i = ~clk_i;

  tar_archive_entry_framer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  // parser state mirrored by the testbench
  parse_phase_e        ph;
  logic [OFS_W-1:0]    blk_ofs;
  logic [SIZE_W-1:0]   size_acc;
  logic                size_stop;
  logic [7:0]          type_b;
  logic                name_empty_q;
  logic                name_done_q;
  logic                name_slash_q;
  logic [SKIP_W-1:0]   skip_left;
  logic [OFFSET_W-1:0] pos;

  result_t     results_due[$];
  logic [7:0]  hdr [BLOCK_BYTES];
  bit          calm = 1'b0;
  bit          burst = 1'b0;
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned images_sent = 0;
  int unsigned words_checked = 0;
  int unsigned results_predicted = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch in %s at word %0d: got %0h, want %0h", what, words_checked, got, want);
    mismatches++;
  endtask

  function automatic result_t make_result(input logic [1:0] st, input logic [SIZE_W-1:0] sz,
                                          input logic [OFFSET_W-1:0] ofs, input logic [7:0] ty,
                                          input logic dir);
    result_t r;
    r.status       = st;
    r.entry_size   = sz;
    r.data_offset  = ofs;
    r.type_code    = ty;
    r.is_directory = dir;
    r.last_result  = 1'b0;
    return r;
  endfunction

  task automatic reset_parser();
    ph           = PH_HEADER;
    blk_ofs      = '0;
    size_acc     = '0;
    size_stop    = 1'b0;
    type_b       = '0;
    name_empty_q = 1'b0;
    name_done_q  = 1'b0;
    name_slash_q = 1'b0;
    skip_left    = '0;
    pos          = '0;
  endtask

  // expected result words for one accepted archive byte
  task automatic parse_archive_byte(input logic [7:0] b, input bit last);
    result_t fresh[$];
    logic    dir;
    pos = pos + 1'b1;
    if (ph == PH_HEADER) begin
      if (blk_ofs == '0) begin
        name_empty_q = (b == 8'h00);
        size_acc     = '0;
        size_stop    = 1'b0;
        type_b       = '0;
        name_done_q  = 1'b0;
        name_slash_q = 1'b0;
      end
      // name field up to its first nul
      if (blk_ofs < NAME_END && !name_done_q) begin
        if (b == 8'h00) name_done_q = 1'b1;
        else name_slash_q = (b == CH_SLASH);
      end
      // octal size: skip non-digits, nul stops
      if (blk_ofs >= SIZE_FIRST && blk_ofs < SIZE_END && !size_stop) begin
        if (b == 8'h00) size_stop = 1'b1;
        else if (b >= CH_ZERO && b <= CH_SEVEN)
          size_acc = (size_acc << 3) + SIZE_W'(b - CH_ZERO);
      end
      if (blk_ofs == TYPE_OFS) type_b = b;
      if (blk_ofs == LAST_OFS) begin
        blk_ofs = '0;
        if (name_empty_q) begin
          fresh.push_back(make_result(ST_EOA, '0, '0, '0, 1'b0));
          ph = PH_DONE;
        end else begin
          dir = (type_b == CH_DIR) || name_slash_q;
          fresh.push_back(make_result(ST_ENTRY, size_acc, pos, type_b, dir));
          skip_left = ({1'b0, size_acc} + SKIP_W'(BLOCK_BYTES - 1)) & ~SKIP_W'(BLOCK_BYTES - 1);
          ph = (skip_left != '0) ? PH_SKIP : PH_HEADER;
        end
      end else begin
        blk_ofs = blk_ofs + 1'b1;
      end
    end else if (ph == PH_SKIP) begin
      if (skip_left != '0) skip_left = skip_left - 1'b1;
      if (skip_left == '0) begin
        ph      = PH_HEADER;
        blk_ofs = '0;
      end
    end
    // image end
    if (last) begin
      if (ph == PH_HEADER || ph == PH_SKIP)
        fresh.push_back(make_result(ST_ENDED, '0, '0, '0, 1'b0));
      reset_parser();
    end
    if (fresh.size() != 0) fresh[fresh.size() - 1].last_result = 1'b1;
    foreach (fresh[k]) results_due.push_back(fresh[k]);
    results_predicted += fresh.size();
  endtask

  function automatic logic [7:0] random_type_byte();
    case ($urandom_range(3, 0))
      0: return CH_DIR;
      1: return CH_ZERO;
      2: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // offer one byte, wait for its handshake, then predict
  task automatic send_byte(input logic [7:0] b, input bit last);
    int unsigned gap;
    bit          ready_seen;
    gap = (calm || burst) ? 0 : $urandom_range(6, 0);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do begin
      @(negedge clk_i);
      ready_seen = s_tready;
      @(posedge clk_i);
    end while (!ready_seen);
    parse_archive_byte(b, last);
    bytes_sent++;
    if (last) images_sent++;
  endtask

  task automatic send_block(input int unsigned count, input bit last_at_end);
    for (int unsigned i = 0; i < count; i++)
      send_byte(hdr[i], last_at_end && (i == count - 1));
  endtask

  task automatic send_data(input longint unsigned count, input bit last_at_end);
    for (longint unsigned i = 0; i < count; i++)
      send_byte(8'($urandom), last_at_end && (i == count - 1));
  endtask

  // fill hdr with a header: random background, then name, size and type
  task automatic build_header(input int unsigned name_chars, input bit slash_end,
                              input logic [7:0] type_ch, input logic [SIZE_W-1:0] size_val,
                              input size_style_e style);
    int unsigned first;
    int unsigned digits;
    for (int i = 0; i < BLOCK_BYTES; i++) hdr[i] = 8'($urandom);
    for (int unsigned i = 0; i < name_chars; i++) hdr[i] = 8'($urandom_range(255, 1));
    if (name_chars != 0) begin
      if (slash_end) hdr[name_chars - 1] = CH_SLASH;
      else if (hdr[name_chars - 1] == CH_SLASH) hdr[name_chars - 1] = "a";
    end
    if (name_chars < NAME_END) hdr[name_chars] = 8'h00;
    first  = SIZE_FIRST;
    digits = 0;
    case (style)
      SZ_PADDED, SZ_EARLY_NUL: begin
        digits = 11;
        hdr[SIZE_END - 1] = 8'h00;
      end
      SZ_SPACED: begin
        first  = SIZE_FIRST + $urandom_range(3, 1);
        digits = SIZE_END - 1 - first;
        for (int unsigned i = SIZE_FIRST; i < first; i++) hdr[i] = " ";
        hdr[SIZE_END - 1] = $urandom_range(1, 0) ? 8'h00 : " ";
      end
      SZ_FULL: digits = 12;
      default: digits = 0;
    endcase
    for (int unsigned i = 0; i < digits; i++)
      hdr[first + i] = CH_ZERO + 8'((size_val >> (3 * (digits - 1 - i))) & 7);
    if (style == SZ_EARLY_NUL) hdr[SIZE_FIRST + $urandom_range(10, 0)] = 8'h00;
    hdr[TYPE_OFS] = type_ch;
  endtask

  task automatic test_lone_bytes();
    // single-byte images offered back to back against a stalling sink
    burst = 1'b1;
    for (int unsigned i = 0; i < LONE_BYTES; i++) send_byte(8'($urandom), 1'b1);
    burst = 1'b0;
  endtask

  task automatic test_entry_at_image_end();
    // random entry header whose last byte is also the image's last byte
    build_header($urandom_range(100, 1), $urandom_range(1, 0) == 1, random_type_byte(),
                 SIZE_W'({$urandom, $urandom}), size_style_e'($urandom_range(4, 0)));
    send_block(BLOCK_BYTES, 1'b1);
    // end-of-archive header ending the image
    build_header(0, 1'b0, CH_DIR, '1, SZ_FULL);
    send_block(BLOCK_BYTES, 1'b1);
  endtask

  task automatic test_skip_cut();
    // largest size on a directory entry, image cut during the data skip
    calm = 1'b1;
    build_header(8, 1'b1, CH_DIR, '1, SZ_FULL);
    send_block(BLOCK_BYTES, 1'b0);
    send_data(CUT_DATA_BYTES, 1'b1);
    calm = 1'b0;
  endtask

  // handshakes and result word sampled mid-cycle, used at the next rising edge
  logic               in_fire_q  = 1'b0;
  logic               out_fire_q = 1'b0;
  logic [TDATA_W-1:0] out_data_q = '0;
  logic               out_last_q = 1'b0;

  always @(negedge clk_i) begin
    in_fire_q  <= rst_ni && s_tvalid && s_tready;
    out_fire_q <= rst_ni && m_tvalid && m_tready;
    out_data_q <= m_tdata;
    out_last_q <= m_tlast;
  end

  // result side stalls: a new wait after each word
  int unsigned hold_left = 0;

  always @(posedge clk_i) begin : sink_pacing
    int unsigned stall;
    if (!rst_ni) begin
      hold_left <= 0;
      m_tready  <= 1'b0;
    end else begin
      if (out_fire_q) stall = calm ? 0 : $urandom_range(6, 0);
      else stall = (hold_left != 0) ? hold_left - 1 : 0;
      hold_left <= stall;
      m_tready  <= (stall == 0);
    end
  end

  // compare each result word with the oldest one due
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_fire_q) begin
      if (results_due.size() == 0) begin
        report_mismatch("word with no result due", 64'(out_data_q), '0);
      end else begin
        want = results_due.pop_front();
        if (out_data_q[1:0] !== want.status)
          report_mismatch("status", 64'(out_data_q[1:0]), 64'(want.status));
        if (out_data_q[37:2] !== want.entry_size)
          report_mismatch("entry_size", 64'(out_data_q[37:2]), 64'(want.entry_size));
        if (out_data_q[69:38] !== want.data_offset)
          report_mismatch("data_offset", 64'(out_data_q[69:38]), 64'(want.data_offset));
        if (out_data_q[77:70] !== want.type_code)
          report_mismatch("type_code", 64'(out_data_q[77:70]), 64'(want.type_code));
        if (out_data_q[78] !== want.is_directory)
          report_mismatch("is_directory", 64'(out_data_q[78]), 64'(want.is_directory));
        if (out_last_q !== want.last_result)
          report_mismatch("last_result", 64'(out_last_q), 64'(want.last_result));
      end
      words_checked++;
    end
  end

  // watchdog on cycles where no word moves
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || in_fire_q || out_fire_q) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("FAIL tar_archive_entry_framer");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_parser();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_lone_bytes();
    test_entry_at_image_end();
    test_skip_cut();
    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("sent %0d archive bytes in %0d images, checked %0d of %0d result words",
             bytes_sent, images_sent, words_checked, results_predicted);
    $display("one-byte images under back-pressure, headers closing an image, a cut data skip");
    if (mismatches == 0) begin
      $display("PASS tar_archive_entry_framer");
    end else begin
      $display("FAIL tar_archive_entry_framer");
    end
    $finish;
  end

endmodule
